// ===== sv/clcd_pkg.sv =====
package clcd_pkg;

  localparam int GLYPH_ROWS  = 8;
  localparam int ROW_IDX_W   = $clog2(GLYPH_ROWS);
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] DDRAM_SET = 8'h80;
  localparam logic [7:0] CGRAM_SET = 8'h40;

  typedef enum logic [1:0] {
    REQ_CMD   = 2'd0,
    REQ_DATA  = 2'd1,
    REQ_AT    = 2'd2,
    REQ_GLYPH = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_CGRAM,
    PH_PATTERN,
    PH_CURSOR,
    PH_DATA
  } phase_t;

  // One byte-level bus request handed from the front to the back
  typedef struct packed {
    logic       rs;
    logic [7:0] value;
    logic       last;
  } clcd_byte_t;

  function automatic logic row_ok(input logic [2:0] row);
    return (row >= 3'd1) && (row <= 3'd4);
  endfunction

  function automatic logic [6:0] row_offset(input logic [1:0] idx);
    logic [6:0] offs;
    unique case (idx)
      2'd0:    offs = 7'h00;
      2'd1:    offs = 7'h40;
      2'd2:    offs = 7'h14;
      default: offs = 7'h54;
    endcase
    return offs;
  endfunction

  // Set-DDRAM-address command; column is one-based and the address wraps in seven bits
  function automatic logic [7:0] cursor_cmd(input logic [2:0] row, input logic [5:0] col);
    logic [1:0] idx;
    logic [6:0] addr;
    idx  = 2'(row - 3'd1);
    addr = row_offset(idx) + {1'b0, col} - 7'd1;
    return DDRAM_SET | {1'b0, addr};
  endfunction

endpackage

// ===== sv/clcd_front.sv =====
module clcd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [1:0]          in_req_type,
  input  logic [7:0]          in_byte_value,
  input  logic [2:0]          in_row,
  input  logic [5:0]          in_column,
  input  logic [2:0]          in_glyph_slot,
  input  logic [63:0]         in_glyph_rows,
  output logic                q_push,
  output clcd_pkg::clcd_byte_t q_wdata,
  input  logic                q_full
);

  clcd_pkg::phase_t phase_r, phase_nxt;
  clcd_pkg::req_t   req_r;
  logic [7:0]       byte_r;
  logic [2:0]       row_r;
  logic [5:0]       col_r;
  logic [2:0]       slot_r;
  logic [63:0]      pat_r;
  logic [clcd_pkg::ROW_IDX_W-1:0] idx_r;

  logic accept;
  logic advance;

  assign advance = (phase_r != clcd_pkg::PH_IDLE) && !q_full;
  assign in_full = !((phase_r == clcd_pkg::PH_IDLE) ||
                     (phase_r == clcd_pkg::PH_DATA && !q_full));
  assign accept  = in_push && !in_full;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (advance) begin
      unique case (phase_r)
        clcd_pkg::PH_CGRAM:   phase_nxt = clcd_pkg::PH_PATTERN;
        clcd_pkg::PH_PATTERN: begin
          if (idx_r == clcd_pkg::ROW_IDX_W'(clcd_pkg::GLYPH_ROWS - 1)) begin
            phase_nxt = clcd_pkg::row_ok(row_r) ? clcd_pkg::PH_CURSOR : clcd_pkg::PH_DATA;
          end
        end
        clcd_pkg::PH_CURSOR:  phase_nxt = clcd_pkg::PH_DATA;
        clcd_pkg::PH_DATA:    phase_nxt = clcd_pkg::PH_IDLE;
        default:              phase_nxt = clcd_pkg::PH_IDLE;
      endcase
    end
    // a new request may enter on the cycle the previous one pushes its last byte
    if (accept) begin
      unique case (clcd_pkg::req_t'(in_req_type))
        clcd_pkg::REQ_GLYPH: phase_nxt = clcd_pkg::PH_CGRAM;
        clcd_pkg::REQ_AT:
          phase_nxt = clcd_pkg::row_ok(in_row) ? clcd_pkg::PH_CURSOR : clcd_pkg::PH_DATA;
        default:             phase_nxt = clcd_pkg::PH_DATA;
      endcase
    end
  end

  // outputs
  always_comb begin
    q_push  = advance;
    q_wdata = '0;
    unique case (phase_r)
      clcd_pkg::PH_CGRAM: begin
        q_wdata.value = clcd_pkg::CGRAM_SET | {2'b00, slot_r, 3'b000};
      end
      clcd_pkg::PH_PATTERN: begin
        q_wdata.rs    = 1'b1;
        q_wdata.value = pat_r[7:0];
      end
      clcd_pkg::PH_CURSOR: begin
        q_wdata.value = clcd_pkg::cursor_cmd(row_r, col_r);
      end
      clcd_pkg::PH_DATA: begin
        q_wdata.rs    = (req_r != clcd_pkg::REQ_CMD);
        q_wdata.value = (req_r == clcd_pkg::REQ_GLYPH) ? {5'b0, slot_r} : byte_r;
        q_wdata.last  = 1'b1;
      end
      default: q_wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= clcd_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= clcd_pkg::req_t'(in_req_type);
      byte_r <= in_byte_value;
      row_r  <= in_row;
      col_r  <= in_column;
      slot_r <= in_glyph_slot;
      pat_r  <= in_glyph_rows;
      idx_r  <= '0;
    end else if (advance && phase_r == clcd_pkg::PH_PATTERN) begin
      // drop the row just sent, next one moves to the low byte
      pat_r <= {8'h00, pat_r[63:8]};
      idx_r <= idx_r + 1'b1;
    end
  end

endmodule

// ===== sv/clcd_fifo.sv =====
module clcd_fifo #(
  parameter int DEPTH = clcd_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  clcd_pkg::clcd_byte_t wdata,
  output logic                 full,
  input  logic                 pop,
  output clcd_pkg::clcd_byte_t rdata,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clcd_pkg::clcd_byte_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("byte queue count beyond depth");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && !pop) |=> !empty)
    else $error("byte queue lost a request");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && empty))
    else $error("byte queue full and empty at once");

endmodule

// ===== sv/clcd_back.sv =====
module clcd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 nibble_mode,
  input  clcd_pkg::clcd_byte_t q_rdata,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_reg_select,
  output logic [7:0]           out_bus_value,
  output logic                 out_last
);

  logic       out_valid_r, out_valid_nxt;
  logic       out_rs_r, out_rs_nxt;
  logic [7:0] out_val_r, out_val_nxt;
  logic       out_last_r, out_last_nxt;
  logic       pend_valid_r, pend_valid_nxt;
  logic       pend_rs_r, pend_rs_nxt;
  logic [3:0] pend_nib_r, pend_nib_nxt;
  logic       pend_last_r, pend_last_nxt;
  logic       load;

  // the output stage refills whenever it is empty or being taken
  assign load  = !out_valid_r || out_pop;
  assign q_pop = load && !pend_valid_r && !q_empty;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_rs_nxt     = out_rs_r;
    out_val_nxt    = out_val_r;
    out_last_nxt   = out_last_r;
    pend_valid_nxt = pend_valid_r;
    pend_rs_nxt    = pend_rs_r;
    pend_nib_nxt   = pend_nib_r;
    pend_last_nxt  = pend_last_r;
    if (load) begin
      priority if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_rs_nxt     = pend_rs_r;
        out_val_nxt    = {4'h0, pend_nib_r};
        out_last_nxt   = pend_last_r;
        pend_valid_nxt = 1'b0;
      end else if (!q_empty) begin
        out_valid_nxt = 1'b1;
        out_rs_nxt    = q_rdata.rs;
        if (nibble_mode) begin
          // high nibble first, hold the low one back
          out_val_nxt    = {4'h0, q_rdata.value[7:4]};
          out_last_nxt   = 1'b0;
          pend_valid_nxt = 1'b1;
          pend_rs_nxt    = q_rdata.rs;
          pend_nib_nxt   = q_rdata.value[3:0];
          pend_last_nxt  = q_rdata.last;
        end else begin
          out_val_nxt  = q_rdata.value;
          out_last_nxt = q_rdata.last;
        end
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rs_r    <= out_rs_nxt;
    out_val_r   <= out_val_nxt;
    out_last_r  <= out_last_nxt;
    pend_rs_r   <= pend_rs_nxt;
    pend_nib_r  <= pend_nib_nxt;
    pend_last_r <= pend_last_nxt;
  end

  assign out_empty      = !out_valid_r;
  assign out_reg_select = out_rs_r;
  assign out_bus_value  = out_val_r;
  assign out_last       = out_last_r;

  a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("low nibble pending without a high nibble shown");

  a_pend_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> !out_last_r)
    else $error("high nibble marked last");

  a_split_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && nibble_mode) |=> pend_valid_r)
    else $error("byte not split in nibble mode");

endmodule

// ===== sv/char_lcd_write_sequencer.sv =====
// Channel   Direction  Handshake              Payload
// in_*      input      push / full            req_type, byte_value, row, column,
//                                             glyph_slot, glyph_rows
// out_*     output     empty / pop            reg_select, bus_value, last
// cfg_*     input      cfg_we                 nibble_mode (cfg_wdata)
//
// One bus write leaves per cycle while out_pop takes it; a request has from 1 up to 22
// writes (custom glyph in nibble mode), set by the back end's nibble splitter.
// The front end pushes one byte per cycle into a QUEUE_DEPTH-entry queue while it has room,
// and takes the next request in the cycle it pushes the last byte of the current one.
// Synchronous active-low reset empties the queue and sets nibble mode.
// A stalled result holds in the output register; the queue lets the front keep working.
module char_lcd_write_sequencer #(
  parameter int QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_byte_value,
  input  logic [2:0]  in_row,
  input  logic [5:0]  in_column,
  input  logic [2:0]  in_glyph_slot,
  input  logic [63:0] in_glyph_rows,
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_reg_select,
  output logic [7:0]  out_bus_value,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  logic                 nibble_mode_r;
  logic                 q_push;
  logic                 q_full;
  logic                 q_pop;
  logic                 q_empty;
  clcd_pkg::clcd_byte_t q_wdata;
  clcd_pkg::clcd_byte_t q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nibble_mode_r <= 1'b1;
    end else if (cfg_we) begin
      nibble_mode_r <= cfg_wdata;
    end
  end

  clcd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_req_type   (in_req_type),
    .in_byte_value (in_byte_value),
    .in_row        (in_row),
    .in_column     (in_column),
    .in_glyph_slot (in_glyph_slot),
    .in_glyph_rows (in_glyph_rows),
    .q_push        (q_push),
    .q_wdata       (q_wdata),
    .q_full        (q_full)
  );

  clcd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  clcd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .nibble_mode    (nibble_mode_r),
    .q_rdata        (q_rdata),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_reg_select (out_reg_select),
    .out_bus_value  (out_bus_value),
    .out_last       (out_last)
  );

endmodule
